// ----- design/assert_macros.svh -----
// Assertion macros shared by the framed intensity command receiver RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FIC_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: assertion failed");
`define FIC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("%m: assertion failed");
`else
`define FIC_ASSERT(label, clk, rst_n, prop)
`define FIC_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ----- design/fic_pkg.sv -----
// Package for the framed intensity command receiver: constants and types.
// No dependencies; used by fic_if, fic_decode, fic_parser and the top level.
`default_nettype none
package fic_pkg;
	localparam int MARK_REPEAT_DEF  = 3;
	localparam int KEPT_PAYLOAD_DEF = 4;
	localparam int MAX_DIGITS       = 3;
	localparam int INTENSITY_W      = 10;

	localparam logic [7:0] OPEN_MARK     = 8'h3C;
	localparam logic [7:0] CLOSE_MARK    = 8'h3E;
	localparam logic [7:0] CMD_INTENSITY = 8'h69;
	localparam logic [7:0] DIGIT_ZERO    = 8'h30;
	localparam logic [7:0] DIGIT_NINE    = 8'h39;

	typedef struct packed {
		logic [INTENSITY_W-1:0] intensity;
		logic                   frame_accepted;
		logic                   intensity_updated;
	} fic_result_t;

	typedef struct packed {
		logic                   is_cmd;
		logic [INTENSITY_W-1:0] value;
	} fic_cmd_t;
endpackage
`default_nettype wire

// ----- design/fic_if.sv -----
// Valid/ready stream interfaces for received bytes and for result beats.
// Depends on fic_pkg.
`default_nettype none
interface fic_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface fic_out_if
	import fic_pkg::*;
;
	logic                   valid;
	logic                   ready;
	logic [INTENSITY_W-1:0] intensity;
	logic                   frame_accepted;
	logic                   intensity_updated;

	modport source (output valid, output intensity, output frame_accepted,
		output intensity_updated, input ready);
	modport sink (input valid, input intensity, input frame_accepted,
		input intensity_updated, output ready);
endinterface
`default_nettype wire

// ----- design/fic_decode.sv -----
// Decimal command decoder: checks for the intensity command and folds up to
// three following digits into a value. Depends on fic_pkg.
`default_nettype none
module fic_decode
	import fic_pkg::*;
#(
	parameter int KEPT_PAYLOAD = KEPT_PAYLOAD_DEF,
	localparam int LEN_W = $clog2(KEPT_PAYLOAD + 1)
) (
	input  wire logic [KEPT_PAYLOAD-1:0][7:0] store,
	input  wire logic [LEN_W-1:0]             len,
	output fic_cmd_t                          cmd
);
	logic [MAX_DIGITS:0][7:0] pad;

	// Positions beyond the kept payload read as non-digits.
	for (genvar p = 0; p <= MAX_DIGITS; p++) begin : g_pad
		if (p < KEPT_PAYLOAD) begin : g_in
			assign pad[p] = store[p];
		end else begin : g_out
			assign pad[p] = '0;
		end
	end

	always_comb begin
		logic                   go;
		logic [INTENSITY_W+3:0] acc;
		logic [3:0]             digit;
		go = 1'b1;
		acc = '0;
		digit = '0;
		for (int p = 1; p <= MAX_DIGITS; p++) begin
			if (p >= KEPT_PAYLOAD || int'(len) <= p
					|| pad[p] < DIGIT_ZERO || pad[p] > DIGIT_NINE) begin
				go = 1'b0;
			end
			if (go) begin
				digit = 4'(pad[p] - DIGIT_ZERO);
				acc = (INTENSITY_W+4)'(acc[INTENSITY_W-1:0] * 4'd10)
					+ (INTENSITY_W+4)'(digit);
			end
		end
		cmd.is_cmd = (len != '0) && (pad[0] == CMD_INTENSITY);
		cmd.value = acc[INTENSITY_W-1:0];
	end
endmodule
`default_nettype wire

// ----- design/fic_parser.sv -----
// Frame parser: mark counting, payload store and held intensity.
// Depends on fic_pkg and fic_decode.
`default_nettype none
module fic_parser
	import fic_pkg::*;
#(
	parameter int MARK_REPEAT  = MARK_REPEAT_DEF,
	parameter int KEPT_PAYLOAD = KEPT_PAYLOAD_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic [7:0]  rx_byte,
	output fic_result_t      result
);
	localparam int LEN_W = $clog2(KEPT_PAYLOAD + 1);
	localparam int IDX_W = $clog2(KEPT_PAYLOAD);
	localparam logic [2:0] MARKS = 3'(MARK_REPEAT);

	localparam logic [1:0] PH_SEEK    = 2'd0;
	localparam logic [1:0] PH_PAYLOAD = 2'd1;
	localparam logic [1:0] PH_END     = 2'd2;

	logic [1:0]                   phase_q, phase_d;
	logic [1:0]                   smc_q, smc_d;
	logic [1:0]                   emc_q, emc_d;
	logic [LEN_W-1:0]             len_q, len_d;
	logic [INTENSITY_W-1:0]       held_q, held_d;
	logic [KEPT_PAYLOAD-1:0][7:0] store_q;
	logic                         wr_en;
	logic                         accepted;
	fic_cmd_t                     cmd;

	fic_decode #(.KEPT_PAYLOAD(KEPT_PAYLOAD)) u_decode (
		.store (store_q),
		.len   (len_q),
		.cmd   (cmd)
	);

	always_comb begin
		phase_d = phase_q;
		smc_d = smc_q;
		emc_d = emc_q;
		len_d = len_q;
		wr_en = 1'b0;
		accepted = 1'b0;
		case (phase_q)
			PH_PAYLOAD: begin
				if (rx_byte == CLOSE_MARK) begin
					if (MARKS <= 3'd1) begin
						accepted = 1'b1;
					end else begin
						phase_d = PH_END;
						emc_d = 2'd1;
					end
				end else if (int'(len_q) < KEPT_PAYLOAD) begin
					wr_en = 1'b1;
					len_d = len_q + LEN_W'(1);
				end
			end
			PH_END: begin
				if (rx_byte == CLOSE_MARK) begin
					if ({1'b0, emc_q} + 3'd1 >= MARKS) begin
						accepted = 1'b1;
					end else begin
						emc_d = emc_q + 2'd1;
					end
				end else begin
					phase_d = PH_SEEK;
					smc_d = '0;
					emc_d = '0;
					len_d = '0;
				end
			end
			default: begin
				phase_d = PH_SEEK;
				if (rx_byte == OPEN_MARK) begin
					if ({1'b0, smc_q} + 3'd1 >= MARKS) begin
						phase_d = PH_PAYLOAD;
						smc_d = '0;
						emc_d = '0;
						len_d = '0;
					end else begin
						smc_d = smc_q + 2'd1;
					end
				end else begin
					smc_d = '0;
				end
			end
		endcase
		// Frame done: restart seeking.
		if (accepted) begin
			phase_d = PH_SEEK;
			smc_d = '0;
			emc_d = '0;
			len_d = '0;
		end
		held_d = (accepted && cmd.is_cmd) ? cmd.value : held_q;
		result.intensity = held_d;
		result.frame_accepted = accepted;
		result.intensity_updated = accepted && cmd.is_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEEK;
			smc_q <= '0;
			emc_q <= '0;
			len_q <= '0;
			held_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			smc_q <= smc_d;
			emc_q <= emc_d;
			len_q <= len_d;
			held_q <= held_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && wr_en) begin
			store_q[len_q[IDX_W-1:0]] <= rx_byte;
		end
	end
endmodule
`default_nettype wire

// ----- design/framed_intensity_command_receiver.sv -----
// Top level of the framed intensity command receiver.
// Depends on fic_pkg, fic_if, fic_parser and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
// The receiver takes one serial byte per beat on rx and returns exactly one
// result beat on res for every byte. It finds frames of MARK_REPEAT '<'
// marks, a payload and MARK_REPEAT '>' marks, keeps the first KEPT_PAYLOAD
// payload bytes, and when an accepted frame starts with 'i' it loads up to
// three following decimal digits into the held intensity (0..999); parsing
// stops at the first non-digit or unwritten position, and no digit gives 0.
// A wrong byte among the closing marks drops the frame. A byte accepted on rx
// is held in the input register; the parser then advances on it and its result
// is captured in the result register, which offers the result beat on res. The
// parser advances one byte per cycle, giving a sustained rate of one beat per
// cycle while res.ready stays high. A stall on res holds the result register,
// and a full input register waits behind it. rx stays ready while the input
// register is empty or can move on into the result register, so two bytes can
// be held during a stall.
module framed_intensity_command_receiver
	import fic_pkg::*;
#(
	parameter int MARK_REPEAT  = MARK_REPEAT_DEF,
	parameter int KEPT_PAYLOAD = KEPT_PAYLOAD_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	fic_in_if.sink   rx,
	fic_out_if.source res
);
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        valid_s2;
	fic_result_t result_s2;
	fic_result_t result;
	logic        advance;

	// Move the input register into the result register when it is free or
	// being drained this cycle.
	assign advance = valid_s1 && (!valid_s2 || res.ready);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	// Payload register: capture the byte on every accepted beat.
	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	fic_parser #(
		.MARK_REPEAT  (MARK_REPEAT),
		.KEPT_PAYLOAD (KEPT_PAYLOAD)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.result  (result)
	);

	// Result register: hold while the sink stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign res.valid = valid_s2;
	assign res.intensity = result_s2.intensity;
	assign res.frame_accepted = result_s2.frame_accepted;
	assign res.intensity_updated = result_s2.intensity_updated;

	`FIC_ASSERT(a_update_needs_frame, clk, arst_n, !valid_s2 || !result_s2.intensity_updated || result_s2.frame_accepted)
	`FIC_ASSERT(a_intensity_range, clk, arst_n, !valid_s2 || result_s2.intensity <= INTENSITY_W'(999))
	`FIC_ASSERT_NEXT(a_stalled_byte_held, clk, arst_n, valid_s1 && !advance, valid_s1 && $stable(byte_s1))
endmodule
`default_nettype wire
